/* rtl/core/rpa_pkg.sv */
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants
// Channel types, register indexes, luma weights and the divide-by-100 helper
// used by both halves of the picture adjust pipeline.
// ----------------------------------------------------------------------------
package rpa_pkg;

	typedef logic [7:0] chan_t;
	// Index 0 is red, 1 is green, 2 is blue.
	typedef chan_t [2:0] rgb8_t;

	localparam int NUM_CH = 3;

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_CONTRAST   = 2'd1,
		REG_SATURATION = 2'd2
	} reg_index_t;

	localparam logic [7:0] BRIGHTNESS_RESET = 8'd8;
	localparam logic [7:0] CONTRAST_RESET   = 8'd78;
	localparam logic [7:0] SATURATION_RESET = 8'd100;

	localparam logic [7:0] LUMA_W_RED   = 8'd77;
	localparam logic [7:0] LUMA_W_GREEN = 8'd150;
	localparam logic [7:0] LUMA_W_BLUE  = 8'd29;

	// ceil(2^23 / 100); exact floor(x/100) for every 16-bit x
	localparam logic [16:0] RECIP100 = 17'd83887;

	function automatic logic [9:0] div100(input logic [15:0] x);
		logic [32:0] p;
		p = {17'b0, x} * {16'b0, RECIP100};
		return p[32:23];
	endfunction

	// Clamp a signed 12-bit value to 0..255.
	function automatic chan_t clamp8(input logic signed [11:0] v);
		chan_t r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 12'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/rpa_contrast.sv */
// ----------------------------------------------------------------------------
// rpa_contrast: widen, contrast gain and brightness offset
// Three register stages: gain product, divide by 100, offset and clamp.
// ----------------------------------------------------------------------------
module rpa_contrast
	import rpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_stall,
	input  logic [14:0]       pixel,
	input  logic [7:0]        contrast,
	input  logic signed [8:0] brightness,
	output logic              dn_valid,
	input  logic              dn_stall,
	output rgb8_t             dn_rgb
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic [NUM_CH-1:0][15:0] prod_s1;
	logic [NUM_CH-1:0][9:0]  quot_s2;
	rgb8_t                   rgb_s3;
	rgb8_t                   wide;

	// A stage loads when it is empty or its content moves on.
	assign en_s3 = !v_s3 || !dn_stall;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign up_stall = !en_s1;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			wide[i] = {pixel[5*i +: 5], pixel[5*i+2 +: 3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			if (en_s1) prod_s1[i] <= {8'b0, wide[i]} * {8'b0, contrast};
			if (en_s2) quot_s2[i] <= div100(prod_s1[i]);
			if (en_s3) rgb_s3[i] <= clamp8($signed({{3{brightness[8]}}, brightness})
				+ $signed({2'b0, quot_s2[i]}));
		end
	end

	assign dn_valid = v_s3;
	assign dn_rgb   = rgb_s3;

endmodule

/* rtl/core/rpa_saturation.sv */
// ----------------------------------------------------------------------------
// rpa_saturation: luma and saturation gain
// Four register stages: luma, gain product, divide by 100, offset and clamp.
// ----------------------------------------------------------------------------
module rpa_saturation
	import rpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	output logic        up_stall,
	input  rgb8_t       up_rgb,
	input  logic [7:0]  saturation,
	output logic        dn_valid,
	input  logic        dn_stall,
	output rgb8_t       dn_rgb
);

	logic v_s4, v_s5, v_s6, v_s7;
	logic en_s4, en_s5, en_s6, en_s7;
	rgb8_t                          rgb_s4;
	chan_t                          luma_s4, luma_s5, luma_s6;
	logic [NUM_CH-1:0][17:0]        prod_s5;
	logic [NUM_CH-1:0][10:0]        delta_s6;
	rgb8_t                          rgb_s7;
	logic [15:0]                    luma_sum;
	logic [NUM_CH-1:0][8:0]         diff;
	logic [NUM_CH-1:0][15:0]        mag;
	logic [NUM_CH-1:0][9:0]         mag_q;

	assign en_s7 = !v_s7 || !dn_stall;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign up_stall = !en_s4;

	assign luma_sum = {8'b0, LUMA_W_RED}   * {8'b0, up_rgb[0]}
	                + {8'b0, LUMA_W_GREEN} * {8'b0, up_rgb[1]}
	                + {8'b0, LUMA_W_BLUE}  * {8'b0, up_rgb[2]};

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			diff[i] = {1'b0, rgb_s4[i]} - {1'b0, luma_s4};
			// magnitude of a product bounded by 255*255
			mag[i]   = prod_s5[i][17] ? 16'(-prod_s5[i]) : prod_s5[i][15:0];
			mag_q[i] = div100(mag[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= up_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rgb_s4  <= up_rgb;
			luma_s4 <= luma_sum[15:8];
		end
		if (en_s5) luma_s5 <= luma_s4;
		if (en_s6) luma_s6 <= luma_s5;
		for (int i = 0; i < NUM_CH; i++) begin
			if (en_s5) prod_s5[i] <= 18'($signed(diff[i]) * $signed({1'b0, saturation}));
			// truncate toward zero: divide the magnitude, then restore the sign
			if (en_s6) delta_s6[i] <= prod_s5[i][17] ? -{1'b0, mag_q[i]} : {1'b0, mag_q[i]};
			if (en_s7) rgb_s7[i] <= clamp8($signed({4'b0, luma_s6})
				+ $signed({delta_s6[i][10], delta_s6[i]}));
		end
	end

	assign dn_valid = v_s7;
	assign dn_rgb   = rgb_s7;

endmodule

/* rtl/core/rgb555_picture_adjust_core.sv */
// ----------------------------------------------------------------------------
// rgb555_picture_adjust_core: brightness, contrast and saturation for RGB555
// Seven-stage pipeline: contrast gain and brightness offset, then luma and
// saturation gain; three 8-bit clamped channels per pixel.
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  ------------------------------
//   pixel in  input      in_valid / in_stall   pixel_rgb555[14:0]
//   pixel out output     out_valid / out_stall out_red, out_green, out_blue
//   config    input      cfg_wr_en             cfg_index[1:0], cfg_wdata[8:0]
//
// One pixel per clock while out_stall is low; a pixel that transfers in passes
// through the seven register stages of the two segments before it can
// transfer out; out_valid is the valid bit of the last stage.
// Each stage loads when empty, so bubbles close up under a stall; in_stall
// rises only when all seven stages hold a pixel and out_stall is high.
// Reset clears the stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module rgb555_picture_adjust_core
	import rpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [14:0] pixel_rgb555,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_wdata
);

	logic signed [8:0] brightness_q;
	logic [7:0]        contrast_q;
	logic [7:0]        saturation_q;

	logic  mid_valid;
	logic  mid_stall;
	rgb8_t mid_rgb;
	rgb8_t out_rgb;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= $signed({1'b0, BRIGHTNESS_RESET});
			contrast_q   <= CONTRAST_RESET;
			saturation_q <= SATURATION_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BRIGHTNESS: brightness_q <= $signed(cfg_wdata);
				REG_CONTRAST:   contrast_q   <= cfg_wdata[7:0];
				REG_SATURATION: saturation_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Stages 1-3: widen each 5-bit channel, scale by contrast/100, offset, clamp.
	rpa_contrast u_contrast (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_stall   (in_stall),
		.pixel      (pixel_rgb555),
		.contrast   (contrast_q),
		.brightness (brightness_q),
		.dn_valid   (mid_valid),
		.dn_stall   (mid_stall),
		.dn_rgb     (mid_rgb)
	);

	// Stages 4-7: luma, scale each channel's distance from luma by saturation/100, clamp again.
	rpa_saturation u_saturation (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (mid_valid),
		.up_stall   (mid_stall),
		.up_rgb     (mid_rgb),
		.saturation (saturation_q),
		.dn_valid   (out_valid),
		.dn_stall   (out_stall),
		.dn_rgb     (out_rgb)
	);

	assign out_red   = out_rgb[0];
	assign out_green = out_rgb[1];
	assign out_blue  = out_rgb[2];

`ifndef SYNTH
	// With the output draining, the pipeline always has room.
	a_drain_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// Input backpressure only comes from a held output transfer.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output");
`endif

endmodule

/* test/tb_rgb555_picture_adjust_core.sv */
// ----------------------------------------------------------------------------
// tb_rgb555_picture_adjust_core: self-checking bench for the picture adjust core
// Streams RGB555 pixels through the core under several brightness, contrast
// and saturation settings and compares each output pixel with a bit-accurate
// software model kept in a small scoreboard. Both handshakes idle at random,
// and one long output hold-off fills the pipeline and pushes back on the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rgb555_picture_adjust_core;
	import rpa_pkg::*;

	localparam int PIPE_LATENCY   = 7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int PHASE_PIXELS   = 50;
	localparam int PHASES_PER_RUN = 7;
	// Index past the end of the register file; the core must ignore it.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} adj_pixel_t;

	// Software model of the core plus the queue of pixels still in flight.
	class picture_scoreboard;
		int brightness;
		int contrast;
		int saturation;
		adj_pixel_t pending_q[$];
		int mismatches;
		int checked;

		function new();
			brightness = int'(BRIGHTNESS_RESET);
			contrast   = int'(CONTRAST_RESET);
			saturation = int'(SATURATION_RESET);
			mismatches = 0;
			checked    = 0;
		endfunction

		// Mirror a register write; only the low eight bits are kept for contrast and saturation.
		function void apply_write(logic [1:0] idx, logic [8:0] data);
			case (idx)
				REG_BRIGHTNESS: brightness = int'($signed(data));
				REG_CONTRAST:   contrast   = int'(data[7:0]);
				REG_SATURATION: saturation = int'(data[7:0]);
				default: ;
			endcase
		endfunction

		function int clip8(int v);
			if (v < 0) return 0;
			if (v > 255) return 255;
			return v;
		endfunction

		// Widen by bit replication, apply gain anchored at black, then offset.
		function int gain_stage(logic [4:0] c5);
			int ch;
			ch = int'({c5, c5[4:2]});
			return clip8(brightness + (ch * contrast) / 100);
		endfunction

		function void note_pixel(logic [14:0] px);
			int r, g, b, luma;
			adj_pixel_t res;
			r = gain_stage(px[4:0]);
			g = gain_stage(px[9:5]);
			b = gain_stage(px[14:10]);
			luma = (77 * r + 150 * g + 29 * b) >> 8;
			// Signed division truncates toward zero here as well.
			res.red   = 8'(clip8(luma + ((r - luma) * saturation) / 100));
			res.green = 8'(clip8(luma + ((g - luma) * saturation) / 100));
			res.blue  = 8'(clip8(luma + ((b - luma) * saturation) / 100));
			pending_q.push_back(res);
		endfunction

		function void check_pixel(chan_t red, chan_t green, chan_t blue);
			adj_pixel_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, red, green, blue);
				mismatches++;
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (want.red !== red) begin
				$display("%0t: red mismatch: expected %0d, got %0d", $time, want.red, red);
				mismatches++;
			end
			if (want.green !== green) begin
				$display("%0t: green mismatch: expected %0d, got %0d",
					$time, want.green, green);
				mismatches++;
			end
			if (want.blue !== blue) begin
				$display("%0t: blue mismatch: expected %0d, got %0d", $time, want.blue, blue);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [14:0] pixel_rgb555;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_wdata;

	picture_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int settings_used;
	int idle_cycles;

	rgb555_picture_adjust_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_rgb555 (pixel_rgb555),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Monitor both channels at the edge; DUT outputs still hold pre-edge values.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && !in_stall) begin
				sb.note_pixel(pixel_rgb555);
			end
			if (out_valid && !out_stall) begin
				sb.check_pixel(out_red, out_green, out_blue);
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Output side: random stalls, plus a long hold-off whenever one is requested.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offer one pixel and return at the edge where it transfers. Valid stays
	// high on return so back-to-back pixels need no extra assignment.
	task automatic send_pixel(input logic [14:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		pixel_rgb555 <= px;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Drop valid, then wait for every pixel in flight to come back out.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.apply_write(idx, data);
	endtask

	// Reprogram all registers with the core idle; also poke the unused index.
	task automatic program_regs(input logic [8:0] bright, input logic [8:0] contr,
			input logic [8:0] sat);
		logic [8:0] junk;
		junk = 9'($urandom_range(511));
		drain_pipeline();
		write_reg(REG_BRIGHTNESS, bright);
		write_reg(REG_CONTRAST, contr);
		write_reg(REG_SATURATION, sat);
		write_reg(REG_UNUSED, junk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Mostly uniform pixels; a quarter built from per-channel extremes.
	function automatic logic [14:0] random_pixel();
		logic [14:0] px;
		px = 15'($urandom_range(32767));
		if ($urandom_range(3) == 0) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				case ($urandom_range(2))
					0: px[ch*5 +: 5] = 5'd0;
					1: px[ch*5 +: 5] = 5'd31;
					default: px[ch*5 +: 5] = 5'($urandom_range(31));
				endcase
			end
		end
		return px;
	endfunction

	initial begin : stimulus
		logic [14:0] corner_px [7];
		logic [8:0] b_val, c_val, s_val;
		corner_px = '{15'h0000, 15'h7FFF, 15'h001F, 15'h03E0, 15'h7C00, 15'h5555, 15'h2AAA};

		sb = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		pixel_rgb555  = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_BRIGHTNESS;
		cfg_wdata     = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 0;
		hold_served   = 0;
		settings_used = 0;
		idle_cycles   = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of the registers, with the channel corners.
		foreach (corner_px[i]) begin
			send_pixel(corner_px[i]);
		end

		// Most negative brightness with full gain: zero channels clamp low, full channels still clamp high.
		program_regs(9'h100, 9'd255, 9'd255);
		send_pixel(15'h7FFF);
		send_pixel(15'h001F);

		// Full offset with zero gain and zero saturation.
		program_regs(9'h0FF, 9'd0, 9'd0);
		send_pixel(15'h0000);
		send_pixel(15'h7C00);

		// Contrast and saturation values wider than their registers: upper bit must be dropped.
		program_regs(9'h101, 9'h1FF, 9'h164);
		send_pixel(15'h7FFF);
		send_pixel(15'h03E0);
		send_pixel(15'h4210);

		// Unity gain with strong saturation pushes channels away from luma.
		program_regs(9'h000, 9'd100, 9'd255);
		send_pixel(15'h001F);
		send_pixel(15'h7C00);
		send_pixel(15'h03E0);
		send_pixel(15'h1234);

		// Random part: three handshake regimes, several settings each.
		for (int regime = 0; regime < 3; regime++) begin
			for (int ph = 0; ph < PHASES_PER_RUN; ph++) begin
				b_val = 9'($urandom_range(511));
				c_val = 9'($urandom_range(511));
				s_val = 9'($urandom_range(511));
				case (ph)
					0: begin
						b_val = 9'h101;
						c_val = 9'd0;
						s_val = 9'd0;
					end
					1: begin
						b_val = 9'h0FF;
						c_val = 9'd255;
						s_val = 9'd255;
					end
					2: b_val = 9'h100;
					default: ;
				endcase
				program_regs(b_val, c_val, s_val);
				case (regime)
					0: begin
						send_idle_pct = 24;
						recv_idle_pct = 65;
					end
					1: begin
						send_idle_pct = 65;
						recv_idle_pct = 24;
					end
					default: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
				endcase
				for (int n = 0; n < PHASE_PIXELS; n++) begin
					// Hold the output off while input keeps coming, so the core fills up.
					if (regime == 2 && ph == 3 && n == 5) begin
						hold_requests++;
					end
					send_pixel(random_pixel());
				end
			end
		end

		drain_pipeline();
		$display("Checked %0d pixels over %0d register settings in three handshake regimes,",
			sb.checked, settings_used + 1);
		$display("with %0d long output hold-off(s) and %0d mismatches.",
			hold_served, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
